// ===== sv/polygon_frustum_cull_macros.svh =====
// assertion macros for the polygon frustum cull block
`ifndef POLYGON_FRUSTUM_CULL_MACROS_SVH
`define POLYGON_FRUSTUM_CULL_MACROS_SVH

// same-cycle implication under reset
`define PFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under reset
`define PFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pfc_pkg.sv =====
// shared constants, types and register codes of the polygon frustum cull block
package pfc_pkg;

	localparam int FRAC_BITS    = 8;
	localparam int VERTEX_SLOTS = 256;
	localparam int SLOT_W       = $clog2(VERTEX_SLOTS);
	localparam int IDX_W        = 8;
	localparam int POS_W        = 24;
	localparam int PLANE_W      = 15;
	localparam int FOV_W        = 16;
	localparam int CNT_W        = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int PROD_W       = FOV_W + 1 + POS_W;
	localparam int CMP_W        = PROD_W + 1;
	localparam int NPL_W        = PLANE_W + FRAC_BITS;
	localparam int DEP_W        = ((POS_W > NPL_W) ? POS_W : NPL_W) + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NEAR       = 3'd0,
		REG_FAR        = 3'd1,
		REG_H_SLOPE    = 3'd2,
		REG_V_SLOPE    = 3'd3,
		REG_DEPTH_ONLY = 3'd4
	} pfc_reg_t;

	typedef struct packed {
		logic [PLANE_W-1:0] near_plane;
		logic [PLANE_W-1:0] far_plane;
		logic [FOV_W-1:0]   h_slope;
		logic [FOV_W-1:0]   v_slope;
		logic               depth_only_mode;
	} pfc_cfg_t;

	typedef struct packed {
		logic       wr;
		logic       load;
		logic       rd;
		logic [1:0] sel;
	} pfc_cmd_t;

	typedef struct packed {
		logic culled;
	} pfc_status_t;

endpackage

// ===== sv/polygon_frustum_cull.sv =====
// top level of the polygon frustum cull block: config registers, controller, datapath
// Usage:
// - input channel (in_valid/in_ready): action 0 writes vertex pos_x/pos_y/pos_z into
//   slot vertex_slot, action 1 tests the polygon of corner_count corners corner_a..d
// - output channel (out_valid/out_ready): one culled flag per polygon test, none per write
// - config channel (cfg_valid/cfg_ready): cfg_index selects near, far, horizontal slope,
//   vertical slope, depth-only mode; cfg_ready is always high; write only while idle
// - a vertex write is stored at its transfer; writes may follow back to back
// - a polygon test reads its four corners from the single-port vertex store one per
//   cycle, passes each through the pipeline registers into the plane tests, then loads
//   the flag into the output register; the next item is taken once the flag is there
// - the result sits in an output register; a stalled receiver holds it while the
//   block takes further vertex writes and starts the next test, which then waits
// - reset clears the handshake state and loads the register defaults; the vertex
//   store is not cleared and reads of unwritten slots give arbitrary flags
module polygon_frustum_cull (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [pfc_pkg::IDX_W-1:0]        vertex_slot,
	input  logic signed [pfc_pkg::POS_W-1:0] pos_x,
	input  logic signed [pfc_pkg::POS_W-1:0] pos_y,
	input  logic signed [pfc_pkg::POS_W-1:0] pos_z,
	input  logic [pfc_pkg::CNT_W-1:0]        corner_count,
	input  logic [pfc_pkg::IDX_W-1:0]        corner_a,
	input  logic [pfc_pkg::IDX_W-1:0]        corner_b,
	input  logic [pfc_pkg::IDX_W-1:0]        corner_c,
	input  logic [pfc_pkg::IDX_W-1:0]        corner_d,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             culled,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pfc_pkg::*;

	`include "polygon_frustum_cull_macros.svh"

	pfc_cfg_t    cfg_q;
	pfc_cmd_t    cmd;
	pfc_status_t status;
	logic        cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_plane      <= PLANE_W'(1);
			cfg_q.far_plane       <= PLANE_W'(1000);
			cfg_q.h_slope         <= FOV_W'(256);
			cfg_q.v_slope         <= FOV_W'(256);
			cfg_q.depth_only_mode <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEAR:       cfg_q.near_plane      <= cfg_data[PLANE_W-1:0];
				REG_FAR:        cfg_q.far_plane       <= cfg_data[PLANE_W-1:0];
				REG_H_SLOPE:    cfg_q.h_slope         <= cfg_data[FOV_W-1:0];
				REG_V_SLOPE:    cfg_q.v_slope         <= cfg_data[FOV_W-1:0];
				REG_DEPTH_ONLY: cfg_q.depth_only_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	pfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.culled    (culled),
		.cmd       (cmd),
		.status    (status)
	);

	pfc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg_q),
		.vertex_slot  (vertex_slot),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.corner_count (corner_count),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.corner_d     (corner_d),
		.status       (status)
	);

	`PFC_ASSERT_NEXT(a_test_busy, in_valid && in_ready && action, !in_ready, "ready after test")
	`PFC_ASSERT_NOW(a_port_conflict, cmd.wr, !cmd.rd && !cmd.load, "store write collides")
	`PFC_ASSERT_NEXT(a_read_start, cmd.load, cmd.rd && cmd.sel == 2'd0, "reads did not start")

endmodule

// ===== sv/pfc_ctrl.sv =====
// controller: input and output handshakes and the corner read sequence
module pfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                culled,
	output pfc_pkg::pfc_cmd_t   cmd,
	input  pfc_pkg::pfc_status_t status
);
	import pfc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} pfc_state_t;

	localparam logic [2:0] LAST_STEP = 3'd5;
	localparam logic [2:0] READS     = 3'd4;

	pfc_state_t state_q, state_d;
	logic [2:0] step_q;
	logic       out_valid_q;
	logic       culled_q;
	logic       accept;
	logic       emit;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign emit     = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign cmd.wr   = accept && !action;
	assign cmd.load = accept && action;
	assign cmd.rd   = (state_q == ST_RUN) && (step_q < READS);
	assign cmd.sel  = step_q[1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (step_q == LAST_STEP) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (emit) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RUN) step_q <= step_q + 3'd1;
			else step_q <= '0;
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) culled_q <= status.culled;
	end

	assign out_valid = out_valid_q;
	assign culled    = culled_q;

endmodule

// ===== sv/pfc_dp.sv =====
// datapath: vertex store, edge products and per-corner plane tests
module pfc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pfc_pkg::pfc_cmd_t              cmd,
	input  pfc_pkg::pfc_cfg_t              cfg,
	input  logic [pfc_pkg::IDX_W-1:0]      vertex_slot,
	input  logic signed [pfc_pkg::POS_W-1:0] pos_x,
	input  logic signed [pfc_pkg::POS_W-1:0] pos_y,
	input  logic signed [pfc_pkg::POS_W-1:0] pos_z,
	input  logic [pfc_pkg::CNT_W-1:0]      corner_count,
	input  logic [pfc_pkg::IDX_W-1:0]      corner_a,
	input  logic [pfc_pkg::IDX_W-1:0]      corner_b,
	input  logic [pfc_pkg::IDX_W-1:0]      corner_c,
	input  logic [pfc_pkg::IDX_W-1:0]      corner_d,
	output pfc_pkg::pfc_status_t           status
);
	import pfc_pkg::*;

	logic [3*POS_W-1:0] mem [VERTEX_SLOTS];

	logic [SLOT_W-1:0] slot_q [4];
	logic [IDX_W-1:0]  corner_in [4];
	logic [1:0]        last;
	logic [SLOT_W-1:0] addr;

	logic                    v_s1, v_s2;
	logic signed [POS_W-1:0] x_s1, y_s1, z_s1;
	logic signed [POS_W-1:0] x_s2, y_s2, z_s2;
	logic signed [PROD_W-1:0] px_s2, py_s2;
	logic signed [FOV_W:0]   fw, fh;

	logic signed [PROD_W-1:0] xc, yc;
	logic signed [CMP_W-1:0]  xc_w, yc_w, x_w, y_w;
	logic signed [DEP_W-1:0]  z_w, nz, fz;

	logic all_near_q, all_far_q, all_left_q, all_right_q, all_below_q, all_above_q;

	assign corner_in[0] = corner_a;
	assign corner_in[1] = corner_b;
	assign corner_in[2] = corner_c;
	assign corner_in[3] = corner_d;

	always_comb begin
		unique case (corner_count) inside
			3'd0, 3'd1: last = 2'd0;
			3'd2:       last = 2'd1;
			3'd3:       last = 2'd2;
			default:    last = 2'd3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < 4; k++) begin
				if (k <= int'(last)) slot_q[k] <= corner_in[k][SLOT_W-1:0];
				else slot_q[k] <= corner_in[last][SLOT_W-1:0];
			end
		end
	end

	assign addr = cmd.wr ? vertex_slot[SLOT_W-1:0] : slot_q[cmd.sel];

	// single port vertex store
	always_ff @(posedge clk) begin
		if (cmd.wr) mem[addr] <= {pos_x, pos_y, pos_z};
		else if (cmd.rd) {x_s1, y_s1, z_s1} <= mem[addr];
	end

	assign fw = $signed({1'b0, cfg.h_slope});
	assign fh = $signed({1'b0, cfg.v_slope});

	always_ff @(posedge clk) begin
		x_s2  <= x_s1;
		y_s2  <= y_s1;
		z_s2  <= z_s1;
		px_s2 <= PROD_W'(fw * z_s1);
		py_s2 <= PROD_W'(fh * z_s1);
	end

	// floor shift of the edge products
	assign xc   = px_s2 >>> FRAC_BITS;
	assign yc   = py_s2 >>> FRAC_BITS;
	assign xc_w = CMP_W'(xc);
	assign yc_w = CMP_W'(yc);
	assign x_w  = CMP_W'(x_s2);
	assign y_w  = CMP_W'(y_s2);
	assign z_w  = DEP_W'(z_s2);
	assign nz   = DEP_W'({cfg.near_plane, {FRAC_BITS{1'b0}}});
	assign fz   = DEP_W'({cfg.far_plane, {FRAC_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			all_near_q  <= 1'b1;
			all_far_q   <= 1'b1;
			all_left_q  <= 1'b1;
			all_right_q <= 1'b1;
			all_below_q <= 1'b1;
			all_above_q <= 1'b1;
		end else if (v_s2) begin
			all_near_q  <= all_near_q  && (z_w < nz);
			all_far_q   <= all_far_q   && (z_w > fz);
			all_left_q  <= all_left_q  && (x_w < -xc_w);
			all_right_q <= all_right_q && (x_w > xc_w);
			all_below_q <= all_below_q && (y_w < -yc_w);
			all_above_q <= all_above_q && (y_w > yc_w);
		end
	end

	assign status.culled = all_near_q || all_far_q ||
		(!cfg.depth_only_mode &&
		 (all_left_q || all_right_q || all_below_q || all_above_q));

endmodule

// ===== sim/polygon_frustum_cull_tb.sv =====
// testbench for the polygon frustum cull block against a behavioral predictor
module polygon_frustum_cull_tb;
	import pfc_pkg::*;

	localparam logic                 ACT_WRITE    = 1'b0;
	localparam logic                 ACT_TEST     = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam longint               POS_MAX      = (64'sd1 <<< (POS_W - 1)) - 1;
	localparam longint               POS_MIN      = -(64'sd1 <<< (POS_W - 1));

	typedef struct packed {
		logic                      action;
		logic [IDX_W-1:0]          slot;
		logic signed [POS_W-1:0]   px;
		logic signed [POS_W-1:0]   py;
		logic signed [POS_W-1:0]   pz;
		logic [CNT_W-1:0]          count;
		logic [IDX_W-1:0]          ca;
		logic [IDX_W-1:0]          cb;
		logic [IDX_W-1:0]          cc;
		logic [IDX_W-1:0]          cd;
	} cull_item_t;

	typedef enum int {
		ZONE_INSIDE, ZONE_NEAR, ZONE_FAR, ZONE_LEFT, ZONE_RIGHT, ZONE_BELOW, ZONE_ABOVE, ZONE_WILD
	} zone_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    action;
	logic [IDX_W-1:0]        vertex_slot;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [CNT_W-1:0]        corner_count;
	logic [IDX_W-1:0]        corner_a;
	logic [IDX_W-1:0]        corner_b;
	logic [IDX_W-1:0]        corner_c;
	logic [IDX_W-1:0]        corner_d;
	logic                    out_valid;
	logic                    out_ready;
	logic                    culled;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// predictor state
	logic signed [POS_W-1:0] mirror_x [VERTEX_SLOTS];
	logic signed [POS_W-1:0] mirror_y [VERTEX_SLOTS];
	logic signed [POS_W-1:0] mirror_z [VERTEX_SLOTS];
	bit                      written  [VERTEX_SLOTS];
	pfc_cfg_t                mirror_cfg;
	logic                    verdict_q [$];

	int send_gap_pct;
	int recv_stall_pct;
	int items_sent;
	int writes_sent;
	int tests_sent;
	int flags_checked;
	int culled_seen;
	int setups_loaded;
	int errors;

	polygon_frustum_cull u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.vertex_slot  (vertex_slot),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.corner_count (corner_count),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.corner_d     (corner_d),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.culled       (culled),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic logic signed [POS_W-1:0] sat_pos(longint v);
		if (v > POS_MAX)
			v = POS_MAX;
		else if (v < POS_MIN)
			v = POS_MIN;
		return v[POS_W-1:0];
	endfunction

	function automatic int used_corners(logic [CNT_W-1:0] count);
		int n;
		n = int'(count);
		if (n < 1)
			n = 1;
		if (n > 4)
			n = 4;
		return n;
	endfunction

	function automatic logic cull_verdict(cull_item_t it);
		logic [IDX_W-1:0] pick [4];
		int               n;
		longint           nz, fz, fw, fh, x, y, z, xc, yc;
		logic             near_all, far_all, left_all, right_all, below_all, above_all;
		n = used_corners(it.count);
		pick[0] = it.ca;
		pick[1] = (n > 1) ? it.cb : pick[0];
		pick[2] = (n > 2) ? it.cc : pick[1];
		pick[3] = (n > 3) ? it.cd : pick[2];
		nz = mirror_cfg.near_plane;
		nz = nz << FRAC_BITS;
		fz = mirror_cfg.far_plane;
		fz = fz << FRAC_BITS;
		fw = mirror_cfg.h_slope;
		fh = mirror_cfg.v_slope;
		near_all  = 1'b1;
		far_all   = 1'b1;
		left_all  = 1'b1;
		right_all = 1'b1;
		below_all = 1'b1;
		above_all = 1'b1;
		for (int k = 0; k < 4; k++) begin
			x = mirror_x[pick[k]];
			y = mirror_y[pick[k]];
			z = mirror_z[pick[k]];
			// arithmetic shift of the exact product rounds toward minus infinity
			xc = (fw * z) >>> FRAC_BITS;
			yc = (fh * z) >>> FRAC_BITS;
			if (!(z < nz))
				near_all = 1'b0;
			if (!(z > fz))
				far_all = 1'b0;
			if (!(x < -xc))
				left_all = 1'b0;
			if (!(x > xc))
				right_all = 1'b0;
			if (!(y < -yc))
				below_all = 1'b0;
			if (!(y > yc))
				above_all = 1'b0;
		end
		return near_all || far_all ||
			(!mirror_cfg.depth_only_mode && (left_all || right_all || below_all || above_all));
	endfunction

	function automatic cull_item_t random_item();
		cull_item_t it;
		it.action = 1'($urandom);
		it.slot   = 8'($urandom);
		it.px     = 24'($urandom);
		it.py     = 24'($urandom);
		it.pz     = 24'($urandom);
		it.count  = 3'($urandom);
		it.ca     = 8'($urandom);
		it.cb     = 8'($urandom);
		it.cc     = 8'($urandom);
		it.cd     = 8'($urandom);
		return it;
	endfunction

	// vertex placed relative to the current planes and edges
	function automatic cull_item_t vertex_item(logic [IDX_W-1:0] slot, zone_t zn);
		cull_item_t it;
		longint     nz, fz, lo, hi, z, xc, yc, xa, ya, x, y, r, t;
		it        = random_item();
		it.action = ACT_WRITE;
		it.slot   = slot;
		if (zn == ZONE_WILD)
			return it;
		nz = mirror_cfg.near_plane;
		nz = nz << FRAC_BITS;
		fz = mirror_cfg.far_plane;
		fz = fz << FRAC_BITS;
		lo = (nz < fz) ? nz : fz;
		hi = (nz < fz) ? fz : nz;
		t  = $urandom_range(0, 32'(hi - lo));
		z  = lo + t;
		if ($urandom_range(0, 3) == 0)
			r = $urandom_range(0, 2);
		else
			r = $urandom_range(0, 65535);
		case (zn)
			ZONE_NEAR: z = nz - 1 - r;
			ZONE_FAR:  z = fz + 1 + r;
			default: ;
		endcase
		z  = sat_pos(z);
		t  = mirror_cfg.h_slope;
		xc = (t * z) >>> FRAC_BITS;
		t  = mirror_cfg.v_slope;
		yc = (t * z) >>> FRAC_BITS;
		xa = (xc < 0) ? -xc : xc;
		ya = (yc < 0) ? -yc : yc;
		if (xa > POS_MAX)
			xa = POS_MAX;
		if (ya > POS_MAX)
			ya = POS_MAX;
		t = $urandom_range(0, 32'(2 * xa));
		x = t - xa;
		t = $urandom_range(0, 32'(2 * ya));
		y = t - ya;
		// land exactly on an edge now and then
		if ($urandom_range(0, 7) == 0)
			x = xc;
		if ($urandom_range(0, 7) == 0)
			y = -yc;
		case (zn)
			ZONE_LEFT:  x = -xc - 1 - r;
			ZONE_RIGHT: x = xc + 1 + r;
			ZONE_BELOW: y = -yc - 1 - r;
			ZONE_ABOVE: y = yc + 1 + r;
			default: ;
		endcase
		it.px = sat_pos(x);
		it.py = sat_pos(y);
		it.pz = sat_pos(z);
		return it;
	endfunction

	function automatic cull_item_t test_item(logic [CNT_W-1:0] count, logic [IDX_W-1:0] s0,
			logic [IDX_W-1:0] s1, logic [IDX_W-1:0] s2, logic [IDX_W-1:0] s3);
		cull_item_t it;
		int         n;
		it        = random_item();
		it.action = ACT_TEST;
		it.count  = count;
		n         = used_corners(count);
		it.ca     = s0;
		if (n > 1)
			it.cb = s1;
		if (n > 2)
			it.cc = s2;
		if (n > 3)
			it.cd = s3;
		return it;
	endfunction

	function automatic logic [IDX_W-1:0] pick_written();
		logic [IDX_W-1:0] s;
		do
			s = 8'($urandom);
		while (!written[s]);
		return s;
	endfunction

	function automatic zone_t random_zone();
		return zone_t'($urandom_range(0, int'(ZONE_WILD)));
	endfunction

	task automatic send_item(cull_item_t it);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_gap_pct);
		end
		in_valid     <= 1'b1;
		action       <= it.action;
		vertex_slot  <= it.slot;
		pos_x        <= it.px;
		pos_y        <= it.py;
		pos_z        <= it.pz;
		corner_count <= it.count;
		corner_a     <= it.ca;
		corner_b     <= it.cb;
		corner_c     <= it.cc;
		corner_d     <= it.cd;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		// transfer done at this edge
		items_sent++;
		if (it.action == ACT_WRITE) begin
			mirror_x[it.slot] = it.px;
			mirror_y[it.slot] = it.py;
			mirror_z[it.slot] = it.pz;
			written[it.slot]  = 1'b1;
			writes_sent++;
		end else begin
			verdict_q.push_back(cull_verdict(it));
			tests_sent++;
		end
	endtask

	// wait for all flags, then let the block sit idle before going on
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		case (idx)
			REG_NEAR:       mirror_cfg.near_plane      = data[PLANE_W-1:0];
			REG_FAR:        mirror_cfg.far_plane       = data[PLANE_W-1:0];
			REG_H_SLOPE:    mirror_cfg.h_slope         = data[FOV_W-1:0];
			REG_V_SLOPE:    mirror_cfg.v_slope         = data[FOV_W-1:0];
			REG_DEPTH_ONLY: mirror_cfg.depth_only_mode = data[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_setting(int lo, int hi);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			5: return 16'($urandom);
			default: return 16'($urandom_range(lo, hi));
		endcase
	endfunction

	task automatic load_random_setup();
		write_reg(REG_NEAR, pick_setting(0, 64));
		write_reg(REG_FAR, pick_setting(200, 4000));
		write_reg(REG_H_SLOPE, pick_setting(64, 1024));
		write_reg(REG_V_SLOPE, pick_setting(64, 1024));
		write_reg(REG_DEPTH_ONLY,
			($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom) & 16'hFFFE);
		if ($urandom_range(0, 2) == 0)
			write_reg(3'($urandom_range(5, 7)), 16'($urandom));
		setups_loaded++;
	endtask

	// four vertices written mostly around one zone, then one polygon over some or all of them
	task automatic send_polygon_group();
		zone_t            zn;
		logic [IDX_W-1:0] s [4];
		zn = random_zone();
		for (int k = 0; k < 4; k++) begin
			s[k] = 8'($urandom);
			send_item(vertex_item(s[k], ($urandom_range(0, 3) == 0) ? random_zone() : zn));
		end
		send_item(test_item(3'($urandom), s[0], s[1], s[2], s[3]));
	endtask

	task automatic run_random(int n_items);
		int stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) == 0)
				drain_block();
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6: send_polygon_group();
				7: send_item(vertex_item(8'($urandom), random_zone()));
				default: send_item(test_item(3'($urandom), pick_written(), pick_written(),
					pick_written(), pick_written()));
			endcase
		end
	endtask

	task automatic test_vertex_extremes();
		cull_item_t it;
		it        = random_item();
		it.action = ACT_WRITE;
		it.slot   = 8'd0;
		it.px     = 24'sh800000;
		it.py     = 24'sh800000;
		it.pz     = 24'sh800000;
		send_item(it);
		it.slot = 8'd255;
		it.px   = 24'sh7FFFFF;
		it.py   = 24'sh7FFFFF;
		it.pz   = 24'sh7FFFFF;
		send_item(it);
		send_item(test_item(3'd1, 8'd0, 8'd0, 8'd0, 8'd0));
		send_item(test_item(3'd1, 8'd255, 8'd0, 8'd0, 8'd0));
	endtask

	// counts of zero and above four fold onto one and four corners
	task automatic test_corner_counts();
		send_item(vertex_item(8'd1, ZONE_NEAR));
		send_item(vertex_item(8'd2, ZONE_NEAR));
		send_item(vertex_item(8'd3, ZONE_NEAR));
		send_item(vertex_item(8'd4, ZONE_INSIDE));
		for (int c = 0; c < 8; c++)
			send_item(test_item(3'(c), 8'd1, 8'd2, 8'd3, 8'd4));
	endtask

	task automatic test_side_planes();
		send_item(vertex_item(8'd5, ZONE_LEFT));
		send_item(vertex_item(8'd6, ZONE_RIGHT));
		send_item(vertex_item(8'd7, ZONE_BELOW));
		send_item(vertex_item(8'd8, ZONE_ABOVE));
		for (int s = 5; s < 9; s++)
			send_item(test_item(3'd1, 8'(s), 8'd0, 8'd0, 8'd0));
	endtask

	task automatic test_register_extremes();
		drain_block();
		write_reg(REG_NEAR, 16'h0000);
		write_reg(REG_FAR, 16'hFFFF);
		write_reg(REG_H_SLOPE, 16'hFFFF);
		write_reg(REG_V_SLOPE, 16'h0000);
		write_reg(REG_DEPTH_ONLY, 16'h0001);
		write_reg(REG_UNMAPPED, 16'hFFFF);
		send_item(test_item(3'd1, 8'd5, 8'd0, 8'd0, 8'd0));
		send_item(test_item(3'd1, 8'd255, 8'd0, 8'd0, 8'd0));
		drain_block();
		write_reg(REG_DEPTH_ONLY, 16'hFFFE);
		send_item(test_item(3'd1, 8'd5, 8'd0, 8'd0, 8'd0));
		send_item(test_item(3'd1, 8'd7, 8'd0, 8'd0, 8'd0));
		setups_loaded++;
	endtask

	task automatic random_phase(int gap_pct, int stall_pct);
		drain_block();
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		for (int p = 0; p < 2; p++) begin
			if (p != 0)
				drain_block();
			load_random_setup();
			run_random(185);
		end
	endtask

	task automatic test_random_slow_receiver();
		random_phase(38, 68);
	endtask

	task automatic test_random_slow_sender();
		random_phase(68, 38);
	endtask

	task automatic test_random_streaming();
		random_phase(0, 0);
	endtask

	task automatic report_error(string what, logic want, logic got);
		errors++;
		if (errors <= 10)
			$display("%t: %s culled expected %b got %b", $realtime, what, want, got);
	endtask

	always @(posedge clk) begin
		logic want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			flags_checked++;
			if (culled === 1'b1)
				culled_seen++;
			if (verdict_q.size() == 0) begin
				report_error("unexpected flag:", 1'bx, culled);
			end else begin
				want = verdict_q.pop_front();
				if (culled !== want)
					report_error("flag mismatch:", want, culled);
			end
		end
	end

	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int waited;
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		action         = ACT_WRITE;
		vertex_slot    = '0;
		pos_x          = '0;
		pos_y          = '0;
		pos_z          = '0;
		corner_count   = '0;
		corner_a       = '0;
		corner_b       = '0;
		corner_c       = '0;
		corner_d       = '0;
		out_ready      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_NEAR;
		cfg_data       = '0;
		mirror_cfg     = '{near_plane: 15'd1, far_plane: 15'd1000, h_slope: 16'd256,
			v_slope: 16'd256, depth_only_mode: 1'b0};
		send_gap_pct   = 38;
		recv_stall_pct = 68;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_vertex_extremes();
		test_corner_counts();
		test_side_planes();
		test_register_extremes();
		test_random_slow_receiver();
		test_random_slow_sender();
		test_random_streaming();

		in_valid <= 1'b0;
		waited = 0;
		while (verdict_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (16) @(posedge clk);
		if (verdict_q.size() != 0) begin
			errors += verdict_q.size();
			$display("%0d expected flags never arrived", verdict_q.size());
		end
		$display("covered %0d vertex writes and %0d polygon tests, %0d flags checked, %0d culled",
			writes_sent, tests_sent, flags_checked, culled_seen);
		$display("register sets: reset defaults plus %0d loaded, %0d errors", setups_loaded, errors);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
